// ----- rtl/cdp_pkg.sv -----
// shared types and constants of the complex dot product and norms block
package cdp_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int PROD_BITS   = 2 * SAMPLE_BITS;
    localparam int DOT_BITS    = 48;
    localparam int SQ_BITS     = 45;
    localparam int NORM_BITS   = 22;
    localparam int ROOT_BITS   = (SQ_BITS + 1) / 2;
    localparam int RAD_BITS    = 2 * ROOT_BITS;
    localparam int REM_BITS    = ROOT_BITS + 1;
    localparam int STEP_BITS   = $clog2(ROOT_BITS);
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
    localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);
    localparam int IN_BITS     = 4 * SAMPLE_BITS;
    localparam int OUT_BITS    = 2 * DOT_BITS + 2 * NORM_BITS;
    localparam int OUT_BYTES_BITS = ((OUT_BITS + 7) / 8) * 8;

    typedef struct packed {
        logic [DOT_BITS-1:0] dot_re;
        logic [DOT_BITS-1:0] dot_im;
        logic [SQ_BITS-1:0]  sq_u;
        logic [SQ_BITS-1:0]  sq_v;
    } cdp_sums_t;

    typedef enum logic {
        BK_IDLE,
        BK_CALC
    } cdp_back_state_t;

endpackage

// ----- rtl/cdp_front.sv -----
// front end: input transfer, products and accumulation into the sum queue
module cdp_front
    import cdp_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [SAMPLE_BITS-1:0] u_re,
    input  logic signed [SAMPLE_BITS-1:0] u_im,
    input  logic signed [SAMPLE_BITS-1:0] v_re,
    input  logic signed [SAMPLE_BITS-1:0] v_im,
    input  logic                          last,
    input  logic                          q_full,
    output logic                          q_push,
    output cdp_sums_t                     q_data
);

    logic                          s1_valid_reg;
    logic                          s1_last_reg;
    logic signed [SAMPLE_BITS-1:0] a_reg, b_reg, c_reg, d_reg;

    logic                          s2_valid_reg;
    logic                          s2_last_reg;
    logic signed [PROD_BITS-1:0]   ac_reg, bd_reg, bc_reg, ad_reg;
    logic signed [PROD_BITS-1:0]   aa_reg, bb_reg, cc_reg, dd_reg;

    logic [DOT_BITS-1:0]           dot_re_reg, dot_re_next;
    logic [DOT_BITS-1:0]           dot_im_reg, dot_im_next;
    logic [SQ_BITS-1:0]            sq_u_reg, sq_u_next;
    logic [SQ_BITS-1:0]            sq_v_reg, sq_v_next;

    logic                          advance;
    logic signed [PROD_BITS:0]     re_add, im_add;
    logic [PROD_BITS-1:0]          squ_add, sqv_add;
    logic [SQ_BITS:0]              squ_sum, sqv_sum;

    assign advance  = !(s2_valid_reg && s2_last_reg && q_full);
    assign in_ready = advance;

    assign re_add  = (PROD_BITS+1)'(ac_reg) + (PROD_BITS+1)'(bd_reg);
    assign im_add  = (PROD_BITS+1)'(bc_reg) - (PROD_BITS+1)'(ad_reg);
    assign squ_add = $unsigned(aa_reg) + $unsigned(bb_reg);
    assign sqv_add = $unsigned(cc_reg) + $unsigned(dd_reg);

    always_comb
    begin
        dot_re_next = dot_re_reg + DOT_BITS'(re_add);
        dot_im_next = dot_im_reg + DOT_BITS'(im_add);
        squ_sum     = {1'b0, sq_u_reg} + (SQ_BITS+1)'(squ_add);
        sqv_sum     = {1'b0, sq_v_reg} + (SQ_BITS+1)'(sqv_add);
        sq_u_next   = squ_sum[SQ_BITS] ? {SQ_BITS{1'b1}} : squ_sum[SQ_BITS-1:0];
        sq_v_next   = sqv_sum[SQ_BITS] ? {SQ_BITS{1'b1}} : sqv_sum[SQ_BITS-1:0];
    end

    assign q_push        = advance && s2_valid_reg && s2_last_reg;
    assign q_data.dot_re = dot_re_next;
    assign q_data.dot_im = dot_im_next;
    assign q_data.sq_u   = sq_u_next;
    assign q_data.sq_v   = sq_v_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            dot_re_reg   <= '0;
            dot_im_reg   <= '0;
            sq_u_reg     <= '0;
            sq_v_reg     <= '0;
        end
        else if (advance)
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            if (s2_valid_reg)
            begin
                if (s2_last_reg)
                begin
                    dot_re_reg <= '0;
                    dot_im_reg <= '0;
                    sq_u_reg   <= '0;
                    sq_v_reg   <= '0;
                end
                else
                begin
                    dot_re_reg <= dot_re_next;
                    dot_im_reg <= dot_im_next;
                    sq_u_reg   <= sq_u_next;
                    sq_v_reg   <= sq_v_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            a_reg       <= u_re;
            b_reg       <= u_im;
            c_reg       <= v_re;
            d_reg       <= v_im;
            s1_last_reg <= last;
            ac_reg      <= a_reg * c_reg;
            bd_reg      <= b_reg * d_reg;
            bc_reg      <= b_reg * c_reg;
            ad_reg      <= a_reg * d_reg;
            aa_reg      <= a_reg * a_reg;
            bb_reg      <= b_reg * b_reg;
            cc_reg      <= c_reg * c_reg;
            dd_reg      <= d_reg * d_reg;
            s2_last_reg <= s1_last_reg;
        end
    end

endmodule

// ----- rtl/cdp_queue.sv -----
// short queue of finished sums between front and back end
module cdp_queue
    import cdp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  cdp_sums_t push_data,
    input  logic      pop,
    output cdp_sums_t head,
    output logic      full,
    output logic      empty
);

    cdp_sums_t            mem [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] wr_ptr_reg;
    logic [QPTR_BITS-1:0] rd_ptr_reg;
    logic [QCNT_BITS-1:0] count_reg;

    assign full  = (count_reg == QCNT_BITS'(QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = mem[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                                                                          : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                                                                          : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ----- rtl/cdp_sqrt.sv -----
// digit-by-digit integer square root, one root bit per cycle, saturated
module cdp_sqrt
    import cdp_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [SQ_BITS-1:0]   radicand,
    output logic                 busy,
    output logic [NORM_BITS-1:0] root
);

    logic                 busy_reg;
    logic [STEP_BITS-1:0] step_reg;
    logic [RAD_BITS-1:0]  rad_reg;
    logic [REM_BITS-1:0]  rem_reg, rem_next;
    logic [ROOT_BITS-1:0] root_reg, root_next;
    logic [REM_BITS+1:0]  rem_sh, trial, rem_sub;
    logic                 ge;

    always_comb
    begin
        rem_sh    = {rem_reg, rad_reg[RAD_BITS-1 -: 2]};
        trial     = {1'b0, root_reg, 2'b01};
        ge        = (rem_sh >= trial);
        rem_sub   = rem_sh - trial;
        rem_next  = ge ? rem_sub[REM_BITS-1:0] : rem_sh[REM_BITS-1:0];
        root_next = {root_reg[ROOT_BITS-2:0], ge};
    end

    assign busy = busy_reg;
    assign root = (root_reg[ROOT_BITS-1:NORM_BITS] != '0) ? {NORM_BITS{1'b1}}
                                                          : root_reg[NORM_BITS-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            step_reg <= STEP_BITS'(ROOT_BITS - 1);
        end
        else if (busy_reg)
        begin
            step_reg <= step_reg - 1'b1;
            if (step_reg == '0)
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rad_reg  <= RAD_BITS'(radicand);
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            rad_reg  <= {rad_reg[RAD_BITS-3:0], 2'b00};
            rem_reg  <= rem_next;
            root_reg <= root_next;
        end
    end

endmodule

// ----- rtl/cdp_back.sv -----
// back end: takes sums from the queue, runs both roots, holds the result
module cdp_back
    import cdp_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  cdp_sums_t            q_head,
    input  logic                 q_empty,
    output logic                 q_pop,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [DOT_BITS-1:0]  dot_re,
    output logic [DOT_BITS-1:0]  dot_im,
    output logic [NORM_BITS-1:0] norm_u,
    output logic [NORM_BITS-1:0] norm_v
);

    cdp_back_state_t      state_reg, state_next;
    logic                 start, load;
    logic                 busy_u, busy_v;
    logic                 out_free, roots_done;
    logic                 out_valid_reg;
    logic [DOT_BITS-1:0]  dre_reg, dim_reg;
    logic [DOT_BITS-1:0]  dot_re_reg, dot_im_reg;
    logic [NORM_BITS-1:0] norm_u_reg, norm_v_reg;
    logic [NORM_BITS-1:0] root_u, root_v;

    cdp_sqrt u_sqrt_u
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .radicand (q_head.sq_u),
        .busy     (busy_u),
        .root     (root_u)
    );

    cdp_sqrt u_sqrt_v
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .radicand (q_head.sq_v),
        .busy     (busy_v),
        .root     (root_v)
    );

    assign out_free   = !out_valid_reg || out_ready;
    assign roots_done = !busy_u && !busy_v;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE:
            begin
                if (!q_empty)
                begin
                    state_next = BK_CALC;
                end
            end
            BK_CALC:
            begin
                if (roots_done && out_free)
                begin
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_comb
    begin
        start = 1'b0;
        load  = 1'b0;
        case (state_reg)
            BK_IDLE:
            begin
                start = !q_empty;
            end
            BK_CALC:
            begin
                load = roots_done && out_free;
            end
            default:
            begin
                start = 1'b0;
                load  = 1'b0;
            end
        endcase
    end

    assign q_pop     = start;
    assign out_valid = out_valid_reg;
    assign dot_re    = dot_re_reg;
    assign dot_im    = dot_im_reg;
    assign norm_u    = norm_u_reg;
    assign norm_v    = norm_v_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dre_reg <= q_head.dot_re;
            dim_reg <= q_head.dot_im;
        end
        if (load)
        begin
            dot_re_reg <= dre_reg;
            dot_im_reg <= dim_reg;
            norm_u_reg <= root_u;
            norm_v_reg <= root_v;
        end
    end

endmodule

// ----- rtl/complex_dot_product_and_norms.sv -----
// top level of the complex dot product and norms block
//
//  channel   dir  fields
//  s_axis    in   s_tdata: u_re, u_im, v_re, v_im; s_tlast: last
//  m_axis    out  m_tdata: dot_re, dot_im, norm_u, norm_v
//
// one element pair per cycle while s_tready is high; the multiply-accumulate is a three stage pipeline
// a result is loaded for output once the 23 step square root, run on both sums
// in parallel, is done and the output register is free
// a queue of two finished sums parts the accumulator from the square root unit
// s_tready drops only while a last item waits at the accumulator and the queue is full
// rst_n clears all control state and the accumulators at once
module complex_dot_product_and_norms
    import cdp_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [IN_BITS-1:0]        s_tdata,   // u_re, u_im, v_re, v_im
    input  logic                      s_tlast,   // last
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [OUT_BYTES_BITS-1:0] m_tdata    // dot_re, dot_im, norm_u, norm_v, zero pad
);

    logic                 q_push, q_pop, q_full, q_empty;
    cdp_sums_t            q_in, q_head;
    logic [DOT_BITS-1:0]  dot_re, dot_im;
    logic [NORM_BITS-1:0] norm_u, norm_v;

    cdp_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .u_re     (s_tdata[SAMPLE_BITS-1:0]),
        .u_im     (s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]),
        .v_re     (s_tdata[3*SAMPLE_BITS-1:2*SAMPLE_BITS]),
        .v_im     (s_tdata[4*SAMPLE_BITS-1:3*SAMPLE_BITS]),
        .last     (s_tlast),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_data   (q_in)
    );

    cdp_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .pop       (q_pop),
        .head      (q_head),
        .full      (q_full),
        .empty     (q_empty)
    );

    cdp_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_head    (q_head),
        .q_empty   (q_empty),
        .q_pop     (q_pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .dot_re    (dot_re),
        .dot_im    (dot_im),
        .norm_u    (norm_u),
        .norm_v    (norm_v)
    );

    assign m_tdata = OUT_BYTES_BITS'({norm_v, norm_u, dot_im, dot_re});

endmodule

// ----- test/cdp_checker.sv -----
// checker that predicts and compares the results of the complex dot product and norms block
`timescale 1ns / 100ps

module cdp_checker
    import cdp_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_tvalid,
    input  logic                      s_tready,
    input  logic [IN_BITS-1:0]        s_tdata,   // u_re, u_im, v_re, v_im
    input  logic                      s_tlast,   // last
    input  logic                      m_tvalid,
    input  logic                      m_tready,
    input  logic [OUT_BYTES_BITS-1:0] m_tdata,   // dot_re, dot_im, norm_u, norm_v, zero pad
    output int                        errors,
    output int                        pending
);

    localparam logic [63:0] ENERGY_CEIL = (64'd1 << SQ_BITS) - 1;
    localparam logic [63:0] NORM_CEIL   = (64'd1 << NORM_BITS) - 1;

    typedef struct {
        logic [DOT_BITS-1:0]  dot_re;
        logic [DOT_BITS-1:0]  dot_im;
        logic [NORM_BITS-1:0] norm_u;
        logic [NORM_BITS-1:0] norm_v;
    } vector_result_t;

    vector_result_t      awaited_results[$];
    logic [DOT_BITS-1:0] inner_re;
    logic [DOT_BITS-1:0] inner_im;
    logic [63:0]         energy_u;
    logic [63:0]         energy_v;

    function automatic logic [63:0] floor_root(input logic [63:0] radicand);
        logic [63:0] root;
        logic [63:0] probe;
        logic [63:0] rest;
        root  = 64'd0;
        probe = 64'h4000_0000_0000_0000;
        rest  = radicand;
        while (probe > rest)
            probe = probe >> 2;
        while (probe != 64'd0)
        begin
            if (rest >= root + probe)
            begin
                rest = rest - (root + probe);
                root = (root >> 1) + probe;
            end
            else
            begin
                root = root >> 1;
            end
            probe = probe >> 2;
        end
        return root;
    endfunction

    function automatic logic [NORM_BITS-1:0] clipped_norm(input logic [63:0] energy);
        logic [63:0] root;
        root = floor_root(energy);
        if (root > NORM_CEIL)
            root = NORM_CEIL;
        return root[NORM_BITS-1:0];
    endfunction

    function automatic logic [63:0] energy_add(input logic [63:0] acc, input longint term);
        logic [63:0] total;
        total = acc + 64'(term);
        return (total > ENERGY_CEIL) ? ENERGY_CEIL : total;
    endfunction

    // accumulate each accepted element pair, queue the result on the last one
    always @(posedge clk or negedge rst_n)
    begin : predict
        longint         ur;
        longint         ui;
        longint         vr;
        longint         vi;
        longint         prod_re;
        longint         prod_im;
        logic [DOT_BITS-1:0] next_re;
        logic [DOT_BITS-1:0] next_im;
        logic [63:0]    next_eu;
        logic [63:0]    next_ev;
        vector_result_t res;
        if (!rst_n)
        begin
            inner_re = '0;
            inner_im = '0;
            energy_u = '0;
            energy_v = '0;
        end
        else if (s_tvalid && s_tready)
        begin
            ur = longint'($signed(s_tdata[0*SAMPLE_BITS +: SAMPLE_BITS]));
            ui = longint'($signed(s_tdata[1*SAMPLE_BITS +: SAMPLE_BITS]));
            vr = longint'($signed(s_tdata[2*SAMPLE_BITS +: SAMPLE_BITS]));
            vi = longint'($signed(s_tdata[3*SAMPLE_BITS +: SAMPLE_BITS]));
            // u times conj v
            prod_re = ur * vr + ui * vi;
            prod_im = ui * vr - ur * vi;
            next_re = inner_re + prod_re[DOT_BITS-1:0];
            next_im = inner_im + prod_im[DOT_BITS-1:0];
            next_eu = energy_add(energy_u, ur * ur + ui * ui);
            next_ev = energy_add(energy_v, vr * vr + vi * vi);
            if (s_tlast)
            begin
                res.dot_re = next_re;
                res.dot_im = next_im;
                res.norm_u = clipped_norm(next_eu);
                res.norm_v = clipped_norm(next_ev);
                awaited_results.push_back(res);
                inner_re = '0;
                inner_im = '0;
                energy_u = '0;
                energy_v = '0;
            end
            else
            begin
                inner_re = next_re;
                inner_im = next_im;
                energy_u = next_eu;
                energy_v = next_ev;
            end
        end
    end

    always @(posedge clk)
    begin : compare
        vector_result_t       want;
        logic [DOT_BITS-1:0]  got_re;
        logic [DOT_BITS-1:0]  got_im;
        logic [NORM_BITS-1:0] got_nu;
        logic [NORM_BITS-1:0] got_nv;
        if (rst_n && m_tvalid && m_tready)
        begin
            got_re = m_tdata[0 +: DOT_BITS];
            got_im = m_tdata[DOT_BITS +: DOT_BITS];
            got_nu = m_tdata[2*DOT_BITS +: NORM_BITS];
            got_nv = m_tdata[2*DOT_BITS+NORM_BITS +: NORM_BITS];
            if (awaited_results.size() == 0)
            begin
                errors = errors + 1;
                $display("%0t: unexpected result transfer, expected none, actual %h %h %h %h",
                         $time, got_re, got_im, got_nu, got_nv);
            end
            else
            begin
                want = awaited_results.pop_front();
                if (got_re !== want.dot_re)
                begin
                    errors = errors + 1;
                    $display("%0t: dot_re mismatch, expected %h, actual %h",
                             $time, want.dot_re, got_re);
                end
                if (got_im !== want.dot_im)
                begin
                    errors = errors + 1;
                    $display("%0t: dot_im mismatch, expected %h, actual %h",
                             $time, want.dot_im, got_im);
                end
                if (got_nu !== want.norm_u)
                begin
                    errors = errors + 1;
                    $display("%0t: norm_u mismatch, expected %0d, actual %0d",
                             $time, want.norm_u, got_nu);
                end
                if (got_nv !== want.norm_v)
                begin
                    errors = errors + 1;
                    $display("%0t: norm_v mismatch, expected %0d, actual %0d",
                             $time, want.norm_v, got_nv);
                end
            end
        end
    end

    always @(negedge clk)
    begin
        pending = awaited_results.size();
    end

endmodule

// ----- test/tb_complex_dot_product_and_norms.sv -----
// testbench top that streams vector pairs into the complex dot product and norms block
`timescale 1ns / 100ps

module tb_complex_dot_product_and_norms;
    import cdp_pkg::*;

    localparam int CYCLE_LIMIT  = 100_000;
    localparam int RANDOM_PAIRS = 440;
    localparam int CALM_AFTER   = 370;
    localparam int LONG_PAIRS   = 32;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 40;

    logic                      clk      = 1'b0;
    logic                      rst_n    = 1'b0;
    logic                      s_tvalid = 1'b0;
    logic                      s_tready;
    logic [IN_BITS-1:0]        s_tdata  = '0;   // u_re, u_im, v_re, v_im
    logic                      s_tlast  = 1'b0; // last
    logic                      m_tvalid;
    logic                      m_tready = 1'b0;
    logic [OUT_BYTES_BITS-1:0] m_tdata;         // dot_re, dot_im, norm_u, norm_v, zero pad

    int errors;
    int pending;
    int cycle_count = 0;
    int pairs_sent  = 0;
    bit calm        = 1'b0;
    bit hold_off    = 1'b0;

    always #4 clk = ~clk;

    complex_dot_product_and_norms dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    cdp_checker u_checker (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .errors   (errors),
        .pending  (pending)
    );

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("complex_dot_product_and_norms test failed");
            $finish;
        end
    end

    task automatic offer_pair(input logic [SAMPLE_BITS-1:0] ure, input logic [SAMPLE_BITS-1:0] uim,
                              input logic [SAMPLE_BITS-1:0] vre, input logic [SAMPLE_BITS-1:0] vim,
                              input logic fin);
        if (!calm && $urandom_range(0, 4) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {vim, vre, uim, ure};
        s_tlast  <= fin;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        pairs_sent++;
    endtask

    function automatic logic [SAMPLE_BITS-1:0] pick_sample();
        logic [SAMPLE_BITS-1:0] val;
        case ($urandom_range(0, 7))
            0:       val = 16'h8000;
            1:       val = 16'h7fff;
            2:       val = 16'h0000;
            3:       val = 16'(int'($urandom_range(0, 8)) - 4);
            default: val = 16'($urandom);
        endcase
        return val;
    endfunction

    task automatic send_vector(input int len);
        for (int i = 0; i < len; i++)
            offer_pair(pick_sample(), pick_sample(), pick_sample(), pick_sample(), i == len - 1);
    endtask

    // sink side: random stalls, plus one long hold-off on request
    initial
    begin
        bit hold_done;
        hold_done = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_off && !hold_done)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_done = 1'b1;
            end
            if (calm || $urandom_range(0, 3) != 0)
            begin
                m_tready <= 1'b1;
            end
            else
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 19) - 1) @(posedge clk);
            end
        end
    end

    initial
    begin
        int len;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // extremes of every field
        offer_pair(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 1'b0);
        offer_pair(16'h8000, 16'h8000, 16'h8000, 16'h8000, 1'b1);
        offer_pair(16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1);
        offer_pair(16'h8000, 16'h8000, 16'h8000, 16'h7fff, 1'b1);
        offer_pair(16'h7fff, 16'h8000, 16'h8000, 16'h7fff, 1'b1);
        offer_pair(16'h0001, 16'hffff, 16'hffff, 16'h0001, 1'b0);
        offer_pair(16'h8000, 16'h0000, 16'h0000, 16'h8000, 1'b0);
        offer_pair(16'h0000, 16'h7fff, 16'h7fff, 16'h0000, 1'b1);
        offer_pair(16'h8000, 16'h8000, 16'h8000, 16'h0000, 1'b1);
        offer_pair(16'h5555, 16'haaaa, 16'h00ff, 16'hff00, 1'b0);
        offer_pair(16'haaaa, 16'h5555, 16'hff00, 16'h00ff, 1'b0);
        offer_pair(16'h1234, 16'hedcb, 16'h8001, 16'h7ffe, 1'b0);
        offer_pair(16'hffff, 16'hffff, 16'hffff, 16'hffff, 1'b1);

        // back-to-back run of extreme samples
        calm = 1'b1;
        for (int i = 0; i < LONG_PAIRS; i++)
            offer_pair(16'h8000, 16'h8000, 16'h8000, 16'h0000, i == LONG_PAIRS - 1);
        calm = 1'b0;

        // sink held off while short vectors keep coming, so the input backs up
        hold_off = 1'b1;
        for (int i = 0; i < 40; i++)
            send_vector($urandom_range(1, 2));

        pairs_sent = 0;
        while (pairs_sent < RANDOM_PAIRS)
        begin
            if (pairs_sent >= CALM_AFTER)
                calm = 1'b1;
            if ($urandom_range(0, 9) == 0)
                len = $urandom_range(9, 40);
            else
                len = $urandom_range(1, 8);
            send_vector(len);
        end
        s_tvalid <= 1'b0;
        s_tlast  <= 1'b0;
        @(posedge clk);

        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (errors == 0)
            $display("complex_dot_product_and_norms test passed");
        else
            $display("complex_dot_product_and_norms test failed");
        $finish;
    end

endmodule
